// ===== rtl/rwqs_pkg.sv =====
// shared types, constants and command/status bundles of the reader-writer query scheduler
package rwqs_pkg;

   // defaults for the top-level parameters
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ID_BITS_DEF     = 8;

   // fixed field widths of the request and result payloads
   localparam int ID_FIELD_W = 8;

   // activity count: -1 writer, 0 idle, n readers
   localparam int                     COUNT_W   = 8;
   localparam logic signed [COUNT_W-1:0] COUNT_MAX = 8'sd127;
   localparam logic signed [COUNT_W-1:0] COUNT_WR  = -8'sd1;

   // one request yields at most this many results
   localparam int MAX_OUT   = 16;
   localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);

   // request kinds
   localparam logic KIND_SUBMIT = 1'b0;
   localparam logic KIND_DONE   = 1'b1;

   // request payload
   typedef struct packed {
      logic                  kind;
      logic [ID_FIELD_W-1:0] request_id;
      logic                  wants_write;
      logic                  instant;
   } req_type;

   // result payload
   typedef struct packed {
      logic [ID_FIELD_W-1:0] granted_id;
      logic                  granted_write;
      logic                  run_inline;
      logic                  rejected;
      logic                  last;
   } rsp_type;

   // activity count update
   typedef enum logic [1:0] {
      CNT_HOLD    = 2'd0,
      CNT_INC     = 2'd1,
      CNT_WRITER  = 2'd2,
      CNT_RELEASE = 2'd3
   } cnt_op_type;

   // where a staged result takes its id and write flag from
   typedef enum logic {
      SRC_INPUT = 1'b0,
      SRC_HEAD  = 1'b1
   } src_type;

   // controller to datapath
   typedef struct packed {
      logic       latch;
      logic       push;
      logic       pop;
      cnt_op_type cnt_op;
      logic       stage;
      src_type    src;
      logic       run_inline;
      logic       rejected;
      logic       flush;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic kind;
      logic wants_write;
      logic instant;
      logic ready;
      logic fill_zero;
      logic fill_full;
      logic cnt_neg;
      logic cnt_zero;
      logic head_write;
      logic head_instant;
   } status_type;

endpackage

// ===== rtl/rwqs_dpath.sv =====
// datapath: wait queue memory, activity count, request latch and result staging
module rwqs_dpath #(
   parameter int QUEUE_DEPTH = rwqs_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_BITS     = rwqs_pkg::ID_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rwqs_pkg::req_type    req_item,
   input  logic                 csr_we,
   input  logic                 csr_wdata,
   input  rwqs_pkg::cmd_type    cmd,
   output rwqs_pkg::status_type status,
   output logic                 rsp_valid,
   output rwqs_pkg::rsp_type    rsp_item
);

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W   = PTR_W + 1;
   localparam int ENTRY_W = ID_BITS + 2;

   // queue memory, entry = {id, write, instant}
   logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] rd_ff;

   logic [PTR_W-1:0]  head_ff, head_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              ready_ff;
   logic signed [rwqs_pkg::COUNT_W-1:0] cnt_ff, cnt_in;

   // latched request
   logic               in_kind_ff, in_wr_ff, in_inst_ff;
   logic [ID_BITS-1:0] in_id_ff;

   // staged result and output register
   logic              pend_valid_ff, pend_valid_in;
   rwqs_pkg::rsp_type pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rwqs_pkg::rsp_type rsp_ff, rsp_in;

   logic [31:0]        id_wide_req, id_wide_src;
   logic [ID_BITS-1:0] src_id;
   logic               src_wr;
   logic [SUM_W-1:0]   tail_sum;
   logic [PTR_W-1:0]   tail;
   logic               fill_full;

   assign fill_full = (fill_ff == FILL_W'(QUEUE_DEPTH));

   // request id masked to the stored width
   assign id_wide_req = 32'(req_item.request_id);

   // tail index, wrapped without a divider
   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(fill_ff);
      if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
      end
      tail = tail_sum[PTR_W-1:0];
   end

   // head and fill
   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (cmd.pop) begin
         if (head_ff == PTR_W'(QUEUE_DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + PTR_W'(1);
         end
         fill_in = fill_ff - FILL_W'(1);
      end else if (cmd.push) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   // activity count
   always_comb begin
      cnt_in = cnt_ff;
      case (cmd.cnt_op)
         rwqs_pkg::CNT_INC: begin
            if (cnt_ff != rwqs_pkg::COUNT_MAX) begin
               cnt_in = cnt_ff + 8'sd1;
            end
         end
         rwqs_pkg::CNT_WRITER: begin
            cnt_in = rwqs_pkg::COUNT_WR;
         end
         rwqs_pkg::CNT_RELEASE: begin
            if (cnt_ff <= 8'sd0) begin
               cnt_in = '0;
            end else begin
               cnt_in = cnt_ff - 8'sd1;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // source of a staged result
   always_comb begin
      if (cmd.src == rwqs_pkg::SRC_HEAD) begin
         src_id = rd_ff[ENTRY_W-1:2];
         src_wr = rd_ff[1];
      end else begin
         src_id = in_id_ff;
         src_wr = in_wr_ff;
      end
      id_wide_src = 32'(src_id);
   end

   // staging: a new result pushes the previous one out as not last
   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = pend_ff;
      rsp_in.last   = cmd.flush;
      rsp_valid_in  = pend_valid_ff && (cmd.stage || cmd.flush);
      if (cmd.stage) begin
         pend_in.granted_id    = id_wide_src[rwqs_pkg::ID_FIELD_W-1:0];
         pend_in.granted_write = src_wr;
         pend_in.run_inline    = cmd.run_inline;
         pend_in.rejected      = cmd.rejected;
         pend_in.last          = 1'b0;
         pend_valid_in         = 1'b1;
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         fill_ff       <= '0;
         cnt_ff        <= '0;
         ready_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            ready_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
      if (cmd.latch) begin
         in_kind_ff <= req_item.kind;
         in_id_ff   <= id_wide_req[ID_BITS-1:0];
         in_wr_ff   <= req_item.wants_write;
         in_inst_ff <= req_item.instant;
      end
   end

   // queue memory: write at the tail, read the next head
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[tail] <= {in_id_ff, in_wr_ff, in_inst_ff};
      end
      rd_ff <= mem[head_in];
   end

   // status to the controller
   always_comb begin
      status.kind         = in_kind_ff;
      status.wants_write  = in_wr_ff;
      status.instant      = in_inst_ff;
      status.ready        = ready_ff;
      status.fill_zero    = (fill_ff == '0);
      status.fill_full    = fill_full;
      status.cnt_neg      = (cnt_ff < 8'sd0);
      status.cnt_zero     = (cnt_ff == 8'sd0);
      status.head_write   = rd_ff[1];
      status.head_instant = rd_ff[0];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== rtl/rwqs_ctrl.sv =====
// controller: dispatch decision and queue drain sequencing
module rwqs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  rwqs_pkg::status_type status,
   output rwqs_pkg::cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_DECIDE     = 6'b000010,
      ST_DRAIN_INST = 6'b000100,
      ST_RELEASE    = 6'b001000,
      ST_DRAIN_READ = 6'b010000,
      ST_FLUSH      = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [rwqs_pkg::OUT_CNT_W-1:0] n_ff, n_in;
   logic room;

   assign room = (n_ff < rwqs_pkg::OUT_CNT_W'(rwqs_pkg::MAX_OUT));

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      n_in           = n_ff;
      cmd            = '0;
      cmd.cnt_op     = rwqs_pkg::CNT_HOLD;
      cmd.src        = rwqs_pkg::SRC_INPUT;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            n_in = '0;
            if (status.kind == rwqs_pkg::KIND_SUBMIT) begin
               if (status.instant && !status.ready && status.fill_zero) begin
                  // inline before the table is ready
                  cmd.stage      = 1'b1;
                  cmd.run_inline = 1'b1;
                  state_in       = ST_FLUSH;
               end else if (status.ready && !status.cnt_neg && status.fill_zero &&
                            (!status.wants_write || status.cnt_zero)) begin
                  // direct dispatch
                  cmd.stage  = 1'b1;
                  cmd.cnt_op = status.wants_write ? rwqs_pkg::CNT_WRITER
                                                  : rwqs_pkg::CNT_INC;
                  state_in   = ST_FLUSH;
               end else if (status.fill_full) begin
                  // queue full, reject
                  cmd.stage    = 1'b1;
                  cmd.rejected = 1'b1;
                  state_in     = ST_FLUSH;
               end else begin
                  // wait in the queue, no result
                  cmd.push = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (!status.ready) begin
               state_in = ST_DRAIN_INST;
            end else begin
               cmd.cnt_op = rwqs_pkg::CNT_RELEASE;
               state_in   = ST_RELEASE;
            end
         end
         ST_DRAIN_INST: begin
            // run head instant requests inline
            if (!status.fill_zero && status.head_instant && room) begin
               cmd.pop        = 1'b1;
               cmd.stage      = 1'b1;
               cmd.src        = rwqs_pkg::SRC_HEAD;
               cmd.run_inline = 1'b1;
               n_in           = n_ff + rwqs_pkg::OUT_CNT_W'(1);
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_RELEASE: begin
            // one head writer, or else the readers ahead of the next writer
            if (status.fill_zero) begin
               state_in = ST_FLUSH;
            end else if (status.cnt_zero && status.head_write) begin
               cmd.pop    = 1'b1;
               cmd.stage  = 1'b1;
               cmd.src    = rwqs_pkg::SRC_HEAD;
               cmd.cnt_op = rwqs_pkg::CNT_WRITER;
               state_in   = ST_FLUSH;
            end else begin
               state_in = ST_DRAIN_READ;
            end
         end
         ST_DRAIN_READ: begin
            if (!status.fill_zero && !status.head_write && room) begin
               cmd.pop    = 1'b1;
               cmd.stage  = 1'b1;
               cmd.src    = rwqs_pkg::SRC_HEAD;
               cmd.cnt_op = rwqs_pkg::CNT_INC;
               n_in       = n_ff + rwqs_pkg::OUT_CNT_W'(1);
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // send the staged result as last
            cmd.flush = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/reader_writer_query_scheduler.sv =====
// top level of the reader-writer query scheduler
//
// Requests enter on req_item with start, taken at a clock edge where busy is
// low. A submit request either dispatches at once, waits in the queue of
// QUEUE_DEPTH entries, or is rejected when that queue is full. A completion
// request releases queued requests: head instant ones while csr_wdata has not
// set table ready, else one head writer or the run of readers before the next
// writer, at most 16 per request.
// Results come out on rsp_item for one cycle each, marked by rsp_valid, with
// last set on the final one of a request; the receiver cannot stall them.
// Order: a submit that dispatches or is rejected goes through the decide and
// flush states before its result shows and busy drops; a queued submit
// returns to idle from decide. A completion before table ready drains
// instants in its own state; once ready it goes through a release state and,
// when it scans for readers, a drain state, and always ends in flush.
// One result per cycle, paced by the single read port of the queue memory.
// csr_we/csr_wdata write table ready; the user must do so only while idle,
// which the block does not enforce. Reset clears the count, the queue
// pointers and table ready; the queue memory needs no clearing pass.
module reader_writer_query_scheduler #(
   parameter int QUEUE_DEPTH = rwqs_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_BITS     = rwqs_pkg::ID_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rwqs_pkg::req_type req_item,
   output logic              rsp_valid,
   output rwqs_pkg::rsp_type rsp_item,
   input  logic              csr_we,
   input  logic              csr_wdata
);

   rwqs_pkg::cmd_type    cmd;
   rwqs_pkg::status_type status;

   // sequencing
   rwqs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // queue, count and result registers
   rwqs_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== sim/tb_reader_writer_query_scheduler.sv =====
// self-checking testbench for the reader-writer query scheduler
`timescale 1ns / 1ps

module tb_reader_writer_query_scheduler;

   localparam int SLOTS     = 16;
   localparam int SETTLE    = 24;
   localparam int TIMEOUT   = 500_000;
   localparam int DUE_DEPTH = 64;

   // one waiting request in the mirror queue
   typedef struct packed {
      logic [7:0] id;
      logic       wr;
      logic       inst;
   } slot_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   rwqs_pkg::req_type req_item;
   logic              rsp_valid;
   rwqs_pkg::rsp_type rsp_item;
   logic              csr_we;
   logic              csr_wdata;

   // mirror of the scheduler state
   logic                                ready_mirror;
   logic signed [rwqs_pkg::COUNT_W-1:0] run_count;
   slot_type                            wait_slots [SLOTS];
   logic [3:0]                          slot_head;
   logic [4:0]                          slot_fill;

   // expected results in arrival order, and those of the request in hand
   rwqs_pkg::rsp_type grants_due [DUE_DEPTH];
   int                due_wr;
   int                due_rd;
   rwqs_pkg::rsp_type step_grants [rwqs_pkg::MAX_OUT];
   int                step_n;
   int                error_count;
   bit                idle_on;

   reader_writer_query_scheduler u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #(TIMEOUT);
      $display("Regression FAIL");
      $finish;
   end

   function automatic rwqs_pkg::req_type make_req(input logic k, input logic [7:0] id,
                                                  input logic wr, input logic inst);
      rwqs_pkg::req_type r;
      r.kind        = k;
      r.request_id  = id;
      r.wants_write = wr;
      r.instant     = inst;
      return r;
   endfunction

   function automatic rwqs_pkg::req_type submit(input logic [7:0] id, input logic wr,
                                                input logic inst);
      return make_req(rwqs_pkg::KIND_SUBMIT, id, wr, inst);
   endfunction

   function automatic rwqs_pkg::req_type completion();
      return make_req(rwqs_pkg::KIND_DONE, 8'($urandom_range(255)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
   endfunction

   function automatic void add_grant(input logic [7:0] id, input logic wr,
                                     input logic inl, input logic rej);
      rwqs_pkg::rsp_type g;
      g.granted_id        = id;
      g.granted_write     = wr;
      g.run_inline        = inl;
      g.rejected          = rej;
      g.last              = 1'b0;
      step_grants[step_n] = g;
      step_n              = step_n + 1;
   endfunction

   function automatic void count_up();
      if (run_count < rwqs_pkg::COUNT_MAX) run_count = run_count + 8'sd1;
   endfunction

   function automatic slot_type pop_slot();
      slot_type e;
      e = wait_slots[slot_head];
      slot_head = slot_head + 4'd1;
      slot_fill = slot_fill - 5'd1;
      return e;
   endfunction

   // queue a request, or reject it when the queue is full
   function automatic void queue_or_reject(input rwqs_pkg::req_type r);
      slot_type e;
      if (slot_fill >= SLOTS) begin
         add_grant(r.request_id, r.wants_write, 1'b0, 1'b1);
      end else begin
         e.id   = r.request_id;
         e.wr   = r.wants_write;
         e.inst = r.instant;
         wait_slots[4'(slot_head + slot_fill)] = e;
         slot_fill = slot_fill + 5'd1;
      end
   endfunction

   // work out the grants that one accepted request causes
   function automatic void predict_grants(input rwqs_pkg::req_type r);
      slot_type e;
      step_n = 0;
      if (r.kind == rwqs_pkg::KIND_SUBMIT) begin
         if (r.instant && !ready_mirror && slot_fill == 0) begin
            add_grant(r.request_id, r.wants_write, 1'b1, 1'b0);
         end else if (run_count < 0 || !ready_mirror) begin
            queue_or_reject(r);
         end else if (r.wants_write) begin
            if (run_count == 0 && slot_fill == 0) begin
               run_count = rwqs_pkg::COUNT_WR;
               add_grant(r.request_id, 1'b1, 1'b0, 1'b0);
            end else begin
               queue_or_reject(r);
            end
         end else if (slot_fill == 0) begin
            count_up();
            add_grant(r.request_id, 1'b0, 1'b0, 1'b0);
         end else begin
            queue_or_reject(r);
         end
      end else begin
         // before ready only head instant requests run, inline
         while (!ready_mirror && slot_fill > 0 && wait_slots[slot_head].inst &&
                step_n < rwqs_pkg::MAX_OUT) begin
            e = pop_slot();
            add_grant(e.id, e.wr, 1'b1, 1'b0);
         end
         if (ready_mirror) begin
            if (run_count <= 0) run_count = '0;
            else run_count = run_count - 8'sd1;
            if (slot_fill > 0) begin
               if (run_count == 0 && wait_slots[slot_head].wr) begin
                  e = pop_slot();
                  run_count = rwqs_pkg::COUNT_WR;
                  add_grant(e.id, 1'b1, 1'b0, 1'b0);
               end else begin
                  // release the run of readers ahead of the next writer
                  while (slot_fill > 0 && !wait_slots[slot_head].wr &&
                         step_n < rwqs_pkg::MAX_OUT) begin
                     e = pop_slot();
                     count_up();
                     add_grant(e.id, 1'b0, 1'b0, 1'b0);
                  end
               end
            end
         end
      end
      if (step_n > 0) step_grants[step_n - 1].last = 1'b1;
      for (int i = 0; i < step_n; i++) begin
         grants_due[due_wr % DUE_DEPTH] = step_grants[i];
         due_wr = due_wr + 1;
      end
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // result checker, sampled mid-cycle
   always @(negedge clock) begin
      rwqs_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (due_wr == due_rd) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_item);
            error_count++;
         end else begin
            want   = grants_due[due_rd % DUE_DEPTH];
            due_rd = due_rd + 1;
            check_field("granted_id", want.granted_id, rsp_item.granted_id);
            check_field("granted_write", want.granted_write, rsp_item.granted_write);
            check_field("run_inline", want.run_inline, rsp_item.run_inline);
            check_field("rejected", want.rejected, rsp_item.rejected);
            check_field("last", want.last, rsp_item.last);
         end
      end
   end

   // send one request; entered and left at a rising edge, start left high
   task automatic send_request(input rwqs_pkg::req_type r);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(99) < 35) gap = $urandom_range(1, 6);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      predict_grants(r);
   endtask

   // hold off until every expected grant is in and the block is idle
   task automatic drain();
      start <= 1'b0;
      while (due_wr != due_rd) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_table_ready(input logic v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      ready_mirror = v;
      csr_we <= 1'b0;
   endtask

   // with the table ready, complete until nothing runs or waits
   task automatic settle_idle();
      while (run_count != 0 || slot_fill != 0) send_request(completion());
   endtask

   // inline instants, dispatch rules, spurious completions
   task automatic test_directed();
      send_request(submit(8'h00, 1'b1, 1'b1));
      send_request(submit(8'hFF, 1'b0, 1'b1));
      send_request(completion());
      send_request(submit(8'h5A, 1'b0, 1'b0));
      send_request(submit(8'hA5, 1'b1, 1'b1));
      send_request(completion());
      write_table_ready(1'b1);
      send_request(completion());
      send_request(completion());
      send_request(submit(8'h11, 1'b0, 1'b1));
      send_request(submit(8'h22, 1'b1, 1'b0));
      send_request(completion());
      send_request(submit(8'h33, 1'b0, 1'b0));
      send_request(completion());
      send_request(completion());
      send_request(completion());
      send_request(completion());
      send_request(submit(8'h80, 1'b1, 1'b0));
      send_request(submit(8'h01, 1'b1, 1'b1));
      send_request(completion());
      send_request(completion());
      send_request(submit(8'h7F, 1'b0, 1'b0));
      send_request(completion());
      drain();
   endtask

   // full queue, rejections and a release of sixteen readers
   task automatic test_queue_full();
      settle_idle();
      send_request(submit(8'($urandom_range(255)), 1'b1, 1'b0));
      repeat (SLOTS) send_request(submit(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1))));
      send_request(submit(8'hC3, 1'b0, 1'b0));
      send_request(submit(8'h3C, 1'b1, 1'b1));
      send_request(completion());
      settle_idle();
      // fill the queue before the table is ready
      write_table_ready(1'b0);
      send_request(submit(8'($urandom_range(255)), 1'b0, 1'b0));
      repeat (SLOTS - 1) send_request(submit(8'($urandom_range(255)), 1'b0, 1'b1));
      send_request(submit(8'h96, 1'b1, 1'b1));
      send_request(completion());
      write_table_ready(1'b1);
      send_request(completion());
      settle_idle();
      // a queue of instants behind a non-instant head, not drained before ready
      write_table_ready(1'b0);
      send_request(submit(8'($urandom_range(255)), 1'b0, 1'b0));
      repeat (SLOTS - 1) send_request(submit(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1));
      send_request(completion());
      write_table_ready(1'b1);
      settle_idle();
      drain();
   endtask

   function automatic rwqs_pkg::req_type random_request(input bit ready_mode);
      rwqs_pkg::req_type r;
      r.request_id  = 8'($urandom_range(255));
      r.instant     = 1'($urandom_range(1));
      r.wants_write = 1'($urandom_range(99) < 25);
      if (ready_mode) begin
         r.kind = ($urandom_range(99) < 45) ? rwqs_pkg::KIND_DONE : rwqs_pkg::KIND_SUBMIT;
      end else begin
         r.kind    = ($urandom_range(99) < 35) ? rwqs_pkg::KIND_DONE : rwqs_pkg::KIND_SUBMIT;
         r.instant = 1'($urandom_range(99) < 60);
      end
      return r;
   endfunction

   // random traffic over several table settings
   task automatic test_random();
      bit modes [5];
      modes = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
      foreach (modes[p]) begin
         write_table_ready(modes[p]);
         idle_on = (p != 2);
         repeat (12) send_request(random_request(modes[p]));
      end
      idle_on = 1'b1;
      drain();
   endtask

   // main sequence
   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_item     = '0;
      csr_we       = 1'b0;
      csr_wdata    = 1'b0;
      ready_mirror = 1'b0;
      run_count    = '0;
      slot_head    = '0;
      slot_fill    = '0;
      due_wr       = 0;
      due_rd       = 0;
      step_n       = 0;
      error_count  = 0;
      idle_on      = 1'b1;
      foreach (wait_slots[i]) wait_slots[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_queue_full();
      test_random();
      write_table_ready(1'b0);
      drain();

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rwqs_pkg.sv
rtl/rwqs_dpath.sv
rtl/rwqs_ctrl.sv
rtl/reader_writer_query_scheduler.sv
sim/tb_reader_writer_query_scheduler.sv
